// ===== src/tts_pkg.sv =====
`default_nettype none

package tts_pkg;

    localparam int TOKEN_BUFFER = 1024;
    localparam int LEN_W        = 10;
    localparam int LEN_CAP_INT  = (TOKEN_BUFFER - 1 < (1 << LEN_W) - 1) ?
                                  TOKEN_BUFFER - 1 : (1 << LEN_W) - 1;
    localparam logic [LEN_W-1:0] LEN_CAP = LEN_W'(LEN_CAP_INT);

    localparam int QUEUE_DEPTH = 4;
    localparam int MAX_RESULTS = 4;

    // scanner modes
    localparam logic [2:0] MODE_IDLE    = 3'd0;
    localparam logic [2:0] MODE_WORD    = 3'd1;
    localparam logic [2:0] MODE_QUOTE   = 3'd2;
    localparam logic [2:0] MODE_COMMENT = 3'd3;
    localparam logic [2:0] MODE_SLASH   = 3'd4;

    // result kinds
    localparam logic [1:0] KIND_CHAR     = 2'd0;
    localparam logic [1:0] KIND_TOK_END  = 2'd1;
    localparam logic [1:0] KIND_TEXT_END = 2'd2;

    // configuration register indexes
    localparam logic [1:0] REG_HIGH_BYTE_AS_SPACE = 2'd0;
    localparam logic [1:0] REG_MAX_TOKEN_LEN      = 2'd1;

    localparam logic [7:0] CH_NUL    = 8'h00;
    localparam logic [7:0] CH_NL     = 8'h0A;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_DQUOTE = 8'h22;
    localparam logic [7:0] CH_APOS   = 8'h27;
    localparam logic [7:0] CH_LPAREN = 8'h28;
    localparam logic [7:0] CH_RPAREN = 8'h29;
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_COLON  = 8'h3A;
    localparam logic [7:0] CH_LBRACE = 8'h7B;
    localparam logic [7:0] CH_RBRACE = 8'h7D;
    localparam logic [7:0] CH_HIGH   = 8'h80;

    typedef struct packed {
        logic [1:0]       kind;
        logic [7:0]       out_char;
        logic             is_quoted;
        logic             truncated;
        logic [LEN_W-1:0] token_len;
    } result_t;

    // all results caused by one input byte
    typedef struct packed {
        logic [2:0]                    count;
        result_t [MAX_RESULTS-1:0]     res;
    } cmd_t;

endpackage

`default_nettype wire

// ===== src/tts_front.sv =====
`default_nettype none

module tts_front (
    input  wire logic                     aclk,
    input  wire logic                     aresetn,
    input  wire logic                     s_tvalid,
    output logic                          s_tready,
    input  wire logic [7:0]               s_tdata,
    input  wire logic                     cfg_valid,
    output logic                          cfg_ready,
    input  wire logic [1:0]               cfg_index,
    input  wire logic [tts_pkg::LEN_W-1:0] cfg_data,
    input  wire logic                     queue_full,
    output logic                          push,
    output tts_pkg::cmd_t                 push_cmd
);

    typedef struct packed {
        logic [2:0]                            mode;
        logic [tts_pkg::LEN_W-1:0]             cnt;
        logic                                  ovf;
        logic [2:0]                            n;
        tts_pkg::result_t [tts_pkg::MAX_RESULTS-1:0] res;
    } scan_t;

    logic                      high_space_reg;
    logic [tts_pkg::LEN_W-1:0] max_len_reg;
    logic [2:0]                mode_reg, mode_next;
    logic [tts_pkg::LEN_W-1:0] cnt_reg, cnt_next;
    logic                      ovf_reg, ovf_next;
    logic [tts_pkg::LEN_W-1:0] lim;
    logic                      accept;
    scan_t                     st;

    function automatic logic is_space(logic [7:0] c, logic hb);
        return (c <= tts_pkg::CH_SPACE) || (hb && c >= tts_pkg::CH_HIGH);
    endfunction

    function automatic logic is_single(logic [7:0] c);
        return c == tts_pkg::CH_LBRACE || c == tts_pkg::CH_RBRACE ||
               c == tts_pkg::CH_LPAREN || c == tts_pkg::CH_RPAREN ||
               c == tts_pkg::CH_APOS   || c == tts_pkg::CH_COLON;
    endfunction

    function automatic scan_t put_res(scan_t s, logic [1:0] kind, logic [7:0] c,
                                      logic q, logic tr, logic [tts_pkg::LEN_W-1:0] len);
        s.res[s.n[1:0]].kind      = kind;
        s.res[s.n[1:0]].out_char  = c;
        s.res[s.n[1:0]].is_quoted = q;
        s.res[s.n[1:0]].truncated = tr;
        s.res[s.n[1:0]].token_len = len;
        s.n = s.n + 3'd1;
        return s;
    endfunction

    function automatic scan_t emit_char(scan_t s, logic [7:0] c, logic q,
                                        logic [tts_pkg::LEN_W-1:0] l);
        if (s.cnt < l) begin
            s = put_res(s, tts_pkg::KIND_CHAR, c, q, 1'b0, '0);
            s.cnt = s.cnt + 1'b1;
        end else begin
            s.ovf = 1'b1;
        end
        return s;
    endfunction

    function automatic scan_t end_token(scan_t s, logic q);
        s = put_res(s, tts_pkg::KIND_TOK_END, 8'h00, q, s.ovf, s.cnt);
        s.cnt  = '0;
        s.ovf  = 1'b0;
        s.mode = tts_pkg::MODE_IDLE;
        return s;
    endfunction

    function automatic scan_t end_text(scan_t s);
        s = put_res(s, tts_pkg::KIND_TEXT_END, 8'h00, 1'b0, 1'b0, '0);
        s.cnt  = '0;
        s.ovf  = 1'b0;
        s.mode = tts_pkg::MODE_IDLE;
        return s;
    endfunction

    function automatic scan_t start_token(scan_t s, logic [7:0] c, logic hb,
                                          logic [tts_pkg::LEN_W-1:0] l);
        if (c == tts_pkg::CH_NUL) begin
            s = end_text(s);
        end else if (is_space(c, hb)) begin
            s.mode = tts_pkg::MODE_IDLE;
        end else if (c == tts_pkg::CH_SLASH) begin
            s.mode = tts_pkg::MODE_SLASH;
        end else if (c == tts_pkg::CH_DQUOTE) begin
            s.mode = tts_pkg::MODE_QUOTE;
        end else if (is_single(c)) begin
            s = emit_char(s, c, 1'b0, l);
            s = end_token(s, 1'b0);
        end else begin
            s = emit_char(s, c, 1'b0, l);
            s.mode = tts_pkg::MODE_WORD;
        end
        return s;
    endfunction

    function automatic scan_t word_next(scan_t s, logic [7:0] c, logic hb,
                                        logic [tts_pkg::LEN_W-1:0] l);
        if (c == tts_pkg::CH_NUL) begin
            s = end_token(s, 1'b0);
            s = end_text(s);
        end else if (is_single(c)) begin
            s = end_token(s, 1'b0);
            s = start_token(s, c, hb, l);
        end else if (is_space(c, hb)) begin
            s = end_token(s, 1'b0);
        end else begin
            s = emit_char(s, c, 1'b0, l);
            s.mode = tts_pkg::MODE_WORD;
        end
        return s;
    endfunction

    assign cfg_ready = 1'b1;
    assign s_tready  = !queue_full;
    assign accept    = s_tvalid && s_tready;

    always_comb begin
        lim = (max_len_reg == '0) ? tts_pkg::LEN_W'(1) : max_len_reg;
        if (lim > tts_pkg::LEN_CAP) begin
            lim = tts_pkg::LEN_CAP;
        end
    end

    always_comb begin
        st      = '0;
        st.mode = mode_reg;
        st.cnt  = cnt_reg;
        st.ovf  = ovf_reg;
        case (mode_reg)
            tts_pkg::MODE_WORD: begin
                st = word_next(st, s_tdata, high_space_reg, lim);
            end
            tts_pkg::MODE_QUOTE: begin
                if (s_tdata == tts_pkg::CH_DQUOTE) begin
                    st = end_token(st, 1'b1);
                end else if (s_tdata == tts_pkg::CH_NUL) begin
                    st = end_token(st, 1'b1);
                    st = end_text(st);
                end else begin
                    st = emit_char(st, s_tdata, 1'b1, lim);
                end
            end
            tts_pkg::MODE_COMMENT: begin
                if (s_tdata == tts_pkg::CH_NUL) begin
                    st = end_text(st);
                end else if (s_tdata == tts_pkg::CH_NL) begin
                    st.mode = tts_pkg::MODE_IDLE;
                end
            end
            tts_pkg::MODE_SLASH: begin
                if (s_tdata == tts_pkg::CH_SLASH) begin
                    st.mode = tts_pkg::MODE_COMMENT;
                end else begin
                    // the held slash opens a word
                    st = emit_char(st, tts_pkg::CH_SLASH, 1'b0, lim);
                    st.mode = tts_pkg::MODE_WORD;
                    st = word_next(st, s_tdata, high_space_reg, lim);
                end
            end
            default: begin
                st = start_token(st, s_tdata, high_space_reg, lim);
            end
        endcase
    end

    always_comb begin
        mode_next = mode_reg;
        cnt_next  = cnt_reg;
        ovf_next  = ovf_reg;
        if (accept) begin
            mode_next = st.mode;
            cnt_next  = st.cnt;
            ovf_next  = st.ovf;
        end
    end

    assign push           = accept && (st.n != 3'd0);
    assign push_cmd.count = st.n;
    assign push_cmd.res   = st.res;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            high_space_reg <= 1'b1;
            max_len_reg    <= tts_pkg::LEN_W'(1023);
            mode_reg       <= tts_pkg::MODE_IDLE;
            cnt_reg        <= '0;
            ovf_reg        <= 1'b0;
        end else begin
            mode_reg <= mode_next;
            cnt_reg  <= cnt_next;
            ovf_reg  <= ovf_next;
            if (cfg_valid && cfg_ready) begin
                if (cfg_index == tts_pkg::REG_HIGH_BYTE_AS_SPACE) begin
                    high_space_reg <= cfg_data[0];
                end else if (cfg_index == tts_pkg::REG_MAX_TOKEN_LEN) begin
                    max_len_reg <= cfg_data;
                end
            end
        end
    end

endmodule

`default_nettype wire

// ===== src/tts_queue.sv =====
`default_nettype none

module tts_queue #(
    parameter int QUEUE_DEPTH = tts_pkg::QUEUE_DEPTH
) (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          push,
    input  tts_pkg::cmd_t      push_cmd,
    output logic               full,
    input  wire logic          pop,
    output logic               head_valid,
    output tts_pkg::cmd_t      head_cmd
);

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);

    tts_pkg::cmd_t    entry_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wptr_reg, wptr_next;
    logic [PTR_W-1:0] rptr_reg, rptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_pop;

    assign full       = (count_reg == CNT_W'(QUEUE_DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_cmd   = entry_reg[rptr_reg];
    assign do_pop     = pop && head_valid;

    always_comb begin
        wptr_next  = wptr_reg;
        rptr_next  = rptr_reg;
        count_next = count_reg;
        if (push) begin
            wptr_next = (wptr_reg == PTR_LAST) ? '0 : wptr_reg + 1'b1;
        end
        if (do_pop) begin
            rptr_next = (rptr_reg == PTR_LAST) ? '0 : rptr_reg + 1'b1;
        end
        if (push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (do_pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wptr_reg] <= push_cmd;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wptr_reg  <= '0;
            rptr_reg  <= '0;
            count_reg <= '0;
        end else begin
            wptr_reg  <= wptr_next;
            rptr_reg  <= rptr_next;
            count_reg <= count_next;
        end
    end

endmodule

`default_nettype wire

// ===== src/tts_back.sv =====
`default_nettype none

module tts_back (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          head_valid,
    input  tts_pkg::cmd_t      head_cmd,
    output logic               pop,
    output logic               m_tvalid,
    input  wire logic          m_tready,
    output logic [23:0]        m_tdata,   // out_char[7:0], truncated[8], token_len[18:9]
    output logic [2:0]         m_tuser,   // kind[1:0], is_quoted[2]
    output logic               m_tlast
);

    logic             valid_reg;
    logic [1:0]       idx_reg, idx_next;
    tts_pkg::result_t res_reg;
    logic             last_reg;
    tts_pkg::result_t cur;
    logic             cur_last;
    logic             load;

    assign cur      = head_cmd.res[idx_reg];
    assign cur_last = ({1'b0, idx_reg} + 3'd1) == head_cmd.count;
    assign load     = head_valid && (!valid_reg || m_tready);
    assign pop      = load && cur_last;

    always_comb begin
        idx_next = idx_reg;
        if (load) begin
            idx_next = cur_last ? 2'd0 : idx_reg + 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            res_reg  <= cur;
            last_reg <= cur_last;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
            idx_reg   <= 2'd0;
        end else begin
            idx_reg <= idx_next;
            if (load) begin
                valid_reg <= 1'b1;
            end else if (m_tready) begin
                valid_reg <= 1'b0;
            end
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = {5'd0, res_reg.token_len, res_reg.truncated, res_reg.out_char};
    assign m_tuser  = {res_reg.is_quoted, res_reg.kind};
    assign m_tlast  = last_reg;

endmodule

`default_nettype wire

// ===== src/text_tokenizer_stream.sv =====
// A result passes from its byte through a command queue slot and then the output register to m_*.
// Throughput: one byte per cycle while a queue slot is free; results leave one per cycle through the
// output register while m_tready is high. A byte giving several results (up to four) fills one
// command queue slot; input stalls only when all QUEUE_DEPTH slots wait for the result side to drain.
// Reset (aresetn low, synchronous): scanner idle, counts cleared, queue and output empty,
// high_byte_as_space = 1, max_token_len = 1023.
`default_nettype none

module text_tokenizer_stream #(
    parameter int QUEUE_DEPTH = tts_pkg::QUEUE_DEPTH
) (
    input  wire logic                      aclk,
    input  wire logic                      aresetn,
    input  wire logic                      s_tvalid,
    output logic                           s_tready,
    input  wire logic [7:0]                s_tdata,   // ch[7:0]
    output logic                           m_tvalid,
    input  wire logic                      m_tready,
    output logic [23:0]                    m_tdata,   // out_char[7:0], truncated[8], token_len[18:9]
    output logic [2:0]                     m_tuser,   // kind[1:0], is_quoted[2]
    output logic                           m_tlast,
    input  wire logic                      cfg_valid,
    output logic                           cfg_ready,
    input  wire logic [1:0]                cfg_index,
    input  wire logic [tts_pkg::LEN_W-1:0] cfg_data
);

    logic          push;
    tts_pkg::cmd_t push_cmd;
    logic          queue_full;
    logic          pop;
    logic          head_valid;
    tts_pkg::cmd_t head_cmd;

    tts_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .queue_full (queue_full),
        .push       (push),
        .push_cmd   (push_cmd)
    );

    tts_queue #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (push),
        .push_cmd   (push_cmd),
        .full       (queue_full),
        .pop        (pop),
        .head_valid (head_valid),
        .head_cmd   (head_cmd)
    );

    tts_back u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .head_valid (head_valid),
        .head_cmd   (head_cmd),
        .pop        (pop),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser),
        .m_tlast    (m_tlast)
    );

endmodule

`default_nettype wire

// ===== sim/token_stream_checker.sv =====
module token_stream_checker
    import tts_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_tvalid,
    input  logic             s_tready,
    input  logic [7:0]       s_tdata,
    input  logic             m_tvalid,
    input  logic             m_tready,
    input  logic [23:0]      m_tdata,
    input  logic [2:0]       m_tuser,
    input  logic             m_tlast,
    input  logic             cfg_valid,
    input  logic             cfg_ready,
    input  logic [1:0]       cfg_index,
    input  logic [LEN_W-1:0] cfg_data,
    output int               fail_count,
    output int               pending,
    output int               results_seen,
    output int               tokens_seen,
    output int               truncated_seen
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        result_t res;
        logic    last;
    } token_out_t;

    token_out_t       expected_q[$];
    token_out_t       byte_results[$];

    // shadow of the scanner and its registers
    logic [2:0]       scan_mode;
    logic [LEN_W-1:0] char_count;
    logic             overflow_seen;
    logic             space_high;
    logic [LEN_W-1:0] max_len;

    function automatic logic [LEN_W-1:0] len_limit();
        logic [LEN_W-1:0] lim;
        lim = max_len;
        if (lim == '0)
            lim = LEN_W'(1);
        if (lim > LEN_CAP)
            lim = LEN_CAP;
        return lim;
    endfunction

    function automatic logic is_blank(input logic [7:0] c);
        return (c <= CH_SPACE) || (space_high && c >= CH_HIGH);
    endfunction

    function automatic logic is_single(input logic [7:0] c);
        return c == CH_LBRACE || c == CH_RBRACE || c == CH_LPAREN ||
               c == CH_RPAREN || c == CH_APOS || c == CH_COLON;
    endfunction

    function automatic void queue_result(input logic [1:0] k, input logic [7:0] c,
                                         input logic q, input logic tr,
                                         input logic [LEN_W-1:0] len);
        token_out_t t;
        t.res.kind      = k;
        t.res.out_char  = c;
        t.res.is_quoted = q;
        t.res.truncated = tr;
        t.res.token_len = len;
        t.last          = 1'b0;
        byte_results.push_back(t);
    endfunction

    function automatic void emit_char(input logic [7:0] c, input logic q);
        if (char_count < len_limit()) begin
            queue_result(KIND_CHAR, c, q, 1'b0, '0);
            char_count = char_count + 1'b1;
        end else begin
            overflow_seen = 1'b1;
        end
    endfunction

    function automatic void end_token(input logic q);
        queue_result(KIND_TOK_END, CH_NUL, q, overflow_seen, char_count);
        char_count    = '0;
        overflow_seen = 1'b0;
        scan_mode     = MODE_IDLE;
    endfunction

    function automatic void end_text();
        queue_result(KIND_TEXT_END, CH_NUL, 1'b0, 1'b0, '0);
        char_count    = '0;
        overflow_seen = 1'b0;
        scan_mode     = MODE_IDLE;
    endfunction

    function automatic void start_token(input logic [7:0] c);
        if (c == CH_NUL) begin
            end_text();
        end else if (is_blank(c)) begin
            scan_mode = MODE_IDLE;
        end else if (c == CH_SLASH) begin
            scan_mode = MODE_SLASH;
        end else if (c == CH_DQUOTE) begin
            scan_mode = MODE_QUOTE;
        end else if (is_single(c)) begin
            emit_char(c, 1'b0);
            end_token(1'b0);
        end else begin
            emit_char(c, 1'b0);
            scan_mode = MODE_WORD;
        end
    endfunction

    function automatic void word_next(input logic [7:0] c);
        if (c == CH_NUL) begin
            end_token(1'b0);
            end_text();
        end else if (is_single(c)) begin
            // word end goes out ahead of the single-character token
            end_token(1'b0);
            start_token(c);
        end else if (is_blank(c)) begin
            end_token(1'b0);
        end else begin
            emit_char(c, 1'b0);
            scan_mode = MODE_WORD;
        end
    endfunction

    function automatic void tokenize_byte(input logic [7:0] c);
        token_out_t t;
        byte_results.delete();
        case (scan_mode)
            MODE_WORD: begin
                word_next(c);
            end
            MODE_QUOTE: begin
                if (c == CH_DQUOTE) begin
                    end_token(1'b1);
                end else if (c == CH_NUL) begin
                    end_token(1'b1);
                    end_text();
                end else begin
                    emit_char(c, 1'b1);
                end
            end
            MODE_COMMENT: begin
                if (c == CH_NUL)
                    end_text();
                else if (c == CH_NL)
                    scan_mode = MODE_IDLE;
            end
            MODE_SLASH: begin
                if (c == CH_SLASH) begin
                    scan_mode = MODE_COMMENT;
                end else begin
                    emit_char(CH_SLASH, 1'b0);
                    scan_mode = MODE_WORD;
                    word_next(c);
                end
            end
            default: begin
                start_token(c);
            end
        endcase
        if (byte_results.size() > 0) begin
            t = byte_results.pop_back();
            t.last = 1'b1;
            byte_results.push_back(t);
        end
        foreach (byte_results[i])
            expected_q.push_back(byte_results[i]);
    endfunction

    function automatic void compare_field(input string name, input int unsigned want,
                                          input int unsigned got);
        if (want != got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            fail_count++;
        end
    endfunction

    function automatic void check_result();
        token_out_t want;
        results_seen++;
        if (expected_q.size() == 0) begin
            $error("kind: expected no transaction, got %0d", m_tuser[1:0]);
            fail_count++;
        end else begin
            want = expected_q.pop_front();
            compare_field("kind", 32'(want.res.kind), 32'(m_tuser[1:0]));
            compare_field("is_quoted", 32'(want.res.is_quoted), 32'(m_tuser[2]));
            compare_field("out_char", 32'(want.res.out_char), 32'(m_tdata[7:0]));
            compare_field("truncated", 32'(want.res.truncated), 32'(m_tdata[8]));
            compare_field("token_len", 32'(want.res.token_len), 32'(m_tdata[18:9]));
            compare_field("tdata padding", 32'd0, 32'(m_tdata[23:19]));
            compare_field("last", 32'(want.last), 32'(m_tlast));
            if (want.res.kind == KIND_TOK_END) begin
                tokens_seen++;
                if (want.res.truncated)
                    truncated_seen++;
            end
        end
    endfunction

    always @(posedge aclk) begin
        if (!aresetn) begin
            scan_mode      = MODE_IDLE;
            char_count     = '0;
            overflow_seen  = 1'b0;
            space_high     = 1'b1;
            max_len        = {LEN_W{1'b1}};
            fail_count     = 0;
            results_seen   = 0;
            tokens_seen    = 0;
            truncated_seen = 0;
            expected_q.delete();
        end else begin
            if (m_tvalid && m_tready)
                check_result();
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    REG_HIGH_BYTE_AS_SPACE: space_high = cfg_data[0];
                    REG_MAX_TOKEN_LEN:      max_len = cfg_data;
                    default: ;
                endcase
            end
            if (s_tvalid && s_tready)
                tokenize_byte(s_tdata);
        end
        pending <= expected_q.size();
    end

endmodule

// ===== sim/testbench.sv =====
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import tts_pkg::*;

    localparam int SETTLE_CYCLES  = 6;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int PHASE_BYTES    = 24;

    // indexes past the register file; the block must ignore them
    localparam logic [1:0] REG_SPARE_2 = 2'd2;
    localparam logic [1:0] REG_SPARE_3 = 2'd3;

    logic             aclk      = 1'b0;
    logic             aresetn   = 1'b0;
    logic             s_tvalid  = 1'b0;
    logic [7:0]       s_tdata   = '0;
    logic             m_tready  = 1'b0;
    logic             cfg_valid = 1'b0;
    logic [1:0]       cfg_index = REG_HIGH_BYTE_AS_SPACE;
    logic [LEN_W-1:0] cfg_data  = '0;

    logic             s_tready;
    logic             m_tvalid;
    logic [23:0]      m_tdata;
    logic [2:0]       m_tuser;
    logic             m_tlast;
    logic             cfg_ready;

    int chk_fail;
    int pending;
    int results_seen;
    int tokens_seen;
    int truncated_seen;

    int bytes_sent   = 0;
    int reg_writes   = 0;
    int tx_idle_pct  = 0;
    int rx_stall_pct = 0;
    int quiet_cycles = 0;

    // word ending at a single char, quote inside a word, empty quotes, slash
    // starting a word, comment, end of text in comment / quote / word / slash
    // / idle, and high bytes as whitespace
    logic [7:0] directed_text [27] = '{
        "a", "b", CH_LBRACE, "x", CH_DQUOTE, "y", CH_COLON, CH_SPACE,
        CH_DQUOTE, CH_DQUOTE, CH_SLASH, "a", CH_SPACE, CH_SLASH, CH_SLASH, "c",
        CH_NUL, CH_DQUOTE, "q", CH_NUL, "w", CH_NUL, CH_SLASH, CH_NUL,
        8'hFF, CH_HIGH, CH_NUL
    };

    logic [7:0] single_chars [6] = '{
        CH_LBRACE, CH_RBRACE, CH_LPAREN, CH_RPAREN, CH_APOS, CH_COLON
    };

    text_tokenizer_stream dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    token_stream_checker token_check (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_tvalid       (s_tvalid),
        .s_tready       (s_tready),
        .s_tdata        (s_tdata),
        .m_tvalid       (m_tvalid),
        .m_tready       (m_tready),
        .m_tdata        (m_tdata),
        .m_tuser        (m_tuser),
        .m_tlast        (m_tlast),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .fail_count     (chk_fail),
        .pending        (pending),
        .results_seen   (results_seen),
        .tokens_seen    (tokens_seen),
        .truncated_seen (truncated_seen)
    );

    always #5 aclk = ~aclk;

    always @(posedge aclk) begin
        m_tready <= ($urandom_range(0, 99) >= rx_stall_pct);
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready) ||
            (cfg_valid && cfg_ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: no transaction for %0d cycles", WATCHDOG_LIMIT);
            $display("RESULT: ERROR");
            $finish;
        end
    end

    task automatic send_byte(input logic [7:0] c);
        while ($urandom_range(0, 99) < tx_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= c;
        @(posedge aclk);
        while (!s_tready)
            @(posedge aclk);
        bytes_sent++;
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [LEN_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge aclk);
        while (!cfg_ready)
            @(posedge aclk);
        reg_writes++;
    endtask

    // pending is registered in the checker, so drain waits for the next edge before it looks
    task automatic drain();
        s_tvalid  <= 1'b0;
        cfg_valid <= 1'b0;
        @(posedge aclk);
        while (pending != 0)
            @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic set_mode(input logic space_high, input logic [LEN_W-1:0] max_len,
                            input int tx_pct, input int rx_pct);
        drain();
        write_reg(REG_HIGH_BYTE_AS_SPACE, LEN_W'(space_high));
        write_reg(REG_MAX_TOKEN_LEN, max_len);
        cfg_valid    <= 1'b0;
        tx_idle_pct  = tx_pct;
        rx_stall_pct = rx_pct;
    endtask

    function automatic logic [7:0] word_char(input logic first);
        if (!first) begin
            case ($urandom_range(0, 9))
                0: return CH_DQUOTE;
                1: return CH_SLASH;
                2: return 8'($urandom_range(128, 255));
                3: return 8'($urandom_range(8'h30, 8'h39));
                default: ;
            endcase
        end
        return 8'($urandom_range(8'h41, 8'h7A));
    endfunction

    function automatic logic [7:0] byte_except(input logic [7:0] stop);
        logic [7:0] c;
        do
            c = 8'($urandom_range(1, 255));
        while (c == stop);
        return c;
    endfunction

    task automatic send_piece();
        int len;
        case ($urandom_range(0, 11))
            0, 1, 2: begin
                if ($urandom_range(0, 3) == 0)
                    send_byte(CH_SLASH);
                len = $urandom_range(1, 6);
                send_byte(word_char(1'b1));
                repeat (len - 1) send_byte(word_char(1'b0));
            end
            3, 4: begin
                send_byte(CH_DQUOTE);
                len = $urandom_range(0, 5);
                repeat (len) send_byte(byte_except(CH_DQUOTE));
                // now and then leave the string open
                if ($urandom_range(0, 5) != 0)
                    send_byte(CH_DQUOTE);
            end
            5: begin
                send_byte(single_chars[$urandom_range(0, 5)]);
            end
            6: begin
                send_byte(CH_SLASH);
                send_byte(CH_SLASH);
                len = $urandom_range(0, 4);
                repeat (len) send_byte(byte_except(CH_NL));
                send_byte(CH_NL);
            end
            7, 8: begin
                len = $urandom_range(1, 2);
                repeat (len) begin
                    if ($urandom_range(0, 1) == 0)
                        send_byte(8'($urandom_range(1, 32)));
                    else
                        send_byte(8'($urandom_range(128, 255)));
                end
            end
            9: begin
                send_byte(CH_NUL);
            end
            default: begin
                send_byte(8'($urandom_range(0, 255)));
            end
        endcase
    endtask

    task automatic send_random(input int n_bytes);
        int start;
        start = bytes_sent;
        while (bytes_sent - start < n_bytes)
            send_piece();
    endtask

    initial begin
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        write_reg(REG_SPARE_2, '1);
        write_reg(REG_SPARE_3, LEN_W'($urandom));
        cfg_valid <= 1'b0;
        foreach (directed_text[i])
            send_byte(directed_text[i]);

        set_mode(1'b0, LEN_W'(3), 0, 0);
        send_random(PHASE_BYTES);
        set_mode(1'b1, LEN_W'(1), 63, 0);
        send_random(PHASE_BYTES);
        set_mode(1'b0, LEN_W'(0), 0, 63);
        send_random(PHASE_BYTES);
        set_mode(1'b1, LEN_CAP, 36, 36);
        send_random(PHASE_BYTES);

        drain();
        $display("Covered %0d text bytes, %0d results, %0d tokens (%0d truncated),",
                 bytes_sent, results_seen, tokens_seen, truncated_seen);
        $display("over %0d register writes and four stall mixes on both channels.",
                 reg_writes);
        if (chk_fail == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
